FILE: hdl/rhv_pkg.sv
// Package for the replica hash vote block: sizes, codes, sequencer states
// and the control/status structs between sequencer and tally unit.
// No dependencies.
`default_nettype none

package rhv_pkg;

  localparam int MAX_PEERS = 16;
  localparam int IDX_W     = $clog2(MAX_PEERS);
  localparam int CNT_W     = $clog2(MAX_PEERS + 1);
  localparam int HASH_W    = 64;
  localparam int ID_W      = 8;
  localparam int DEC_W     = 2;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PEERS);

  typedef enum logic [DEC_W-1:0] {
    DEC_NONE            = 2'd0,
    DEC_MINORITY        = 2'd1,
    DEC_MASTER_MINORITY = 2'd2,
    DEC_ALL             = 2'd3
  } decision_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_WR,
    ST_DEC,
    ST_OUT
  } state_e;

  // sequencer -> tally
  typedef struct packed {
    logic             clr;      // restart accumulators for a new sweep
    logic             dec_mode; // compare against master instead of new hash
    logic             vld;      // read data of entry idx is present
    logic [IDX_W-1:0] idx;
    logic             wr_en;    // store own match count of the new entry
    logic [IDX_W-1:0] wr_idx;
  } tally_ctrl_t;

  // tally -> sequencer
  typedef struct packed {
    logic [CNT_W-1:0] master_matches;
    logic [CNT_W-1:0] largest;
  } tally_stat_t;

endpackage

`default_nettype wire

FILE: hdl/replica_hash_vote_decision.sv
// Top level of the replica hash vote block: sequencer, hash store and
// tally unit. Depends on rhv_pkg, rhv_ctrl, rhv_hash_mem, rhv_tally.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | request   | in_valid_i / in_stall_o | peer_hash_i, claimed_leader_i,
//           |           |                         | node_id_i, last_peer_i
//   out     | result    | out_valid_o/out_stall_i | decision_o
//
// Steps: each peer of a group is captured, compared with the stored entries in a sweep
// through the single read port and shared comparator, then stored. The marked peer
// adds a decide sweep and one result load; a request past capacity is not compared or
// stored, and when marked it goes on to the decide sweep and the load.
// Reset clears the group state and the result valid; the hash store needs no clearing.
// in_stall_o is high unless idle; a stalled result holds and only the next load waits.
`default_nettype none

module replica_hash_vote_decision
  import rhv_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [HASH_W-1:0] peer_hash_i,
  input  wire logic [ID_W-1:0]   claimed_leader_i,
  input  wire logic [ID_W-1:0]   node_id_i,
  input  wire logic              last_peer_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [DEC_W-1:0]  decision_o
);

  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic [HASH_W-1:0] mem_rd_data;
  logic [HASH_W-1:0] item_hash;
  logic [HASH_W-1:0] master;
  tally_ctrl_t       tally_ctrl;
  tally_stat_t       tally_stat;

  // Sequence each request: compare sweep and store (skipped past capacity), and on
  // the marked peer a decide sweep followed by the result load.
  rhv_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .peer_hash_i      (peer_hash_i),
    .claimed_leader_i (claimed_leader_i),
    .node_id_i        (node_id_i),
    .last_peer_i      (last_peer_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .decision_o       (decision_o),
    .mem_wr_en_o      (mem_wr_en),
    .mem_wr_addr_o    (mem_wr_addr),
    .mem_rd_en_o      (mem_rd_en),
    .mem_rd_addr_o    (mem_rd_addr),
    .item_hash_o      (item_hash),
    .master_o         (master),
    .tally_ctrl_o     (tally_ctrl),
    .tally_stat_i     (tally_stat)
  );

  // Hold the hashes of the current group.
  rhv_hash_mem u_hash_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (item_hash),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // Compare each stored hash against the new hash or the master hash and
  // keep the match tallies.
  rhv_tally u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (tally_ctrl),
    .rd_data_i   (mem_rd_data),
    .item_hash_i (item_hash),
    .master_i    (master),
    .stat_o      (tally_stat)
  );

endmodule

`default_nettype wire

FILE: hdl/rhv_hash_mem.sv
// Hash store: one write port, one read port with registered read data.
// Depends on rhv_pkg.
`default_nettype none

module rhv_hash_mem
  import rhv_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [IDX_W-1:0]  wr_addr_i,
  input  wire logic [HASH_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [IDX_W-1:0]  rd_addr_i,
  output logic      [HASH_W-1:0] rd_data_o
);

  logic [HASH_W-1:0] mem [MAX_PEERS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rhv_tally.sv
// Tally unit: shared 64-bit equality comparator, per-entry match counts and
// the sweep accumulators (own matches, master matches, largest group).
// Depends on rhv_pkg.
`default_nettype none

module rhv_tally
  import rhv_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tally_ctrl_t       ctrl_i,
  input  wire logic [HASH_W-1:0] rd_data_i,
  input  wire logic [HASH_W-1:0] item_hash_i,
  input  wire logic [HASH_W-1:0] master_i,
  output tally_stat_t            stat_o
);

  logic [CNT_W-1:0]  cnt_q [MAX_PEERS];
  logic [CNT_W-1:0]  same_q, same_d;
  logic [CNT_W-1:0]  mm_q, mm_d;
  logic [CNT_W-1:0]  largest_q, largest_d;
  logic [HASH_W-1:0] operand;
  logic              eq;
  logic [CNT_W-1:0]  cur_cnt;

  assign operand = ctrl_i.dec_mode ? master_i : item_hash_i;
  assign eq      = (rd_data_i == operand);
  assign cur_cnt = cnt_q[ctrl_i.idx];

  always_comb begin
    same_d    = same_q;
    mm_d      = mm_q;
    largest_d = largest_q;
    if (ctrl_i.clr) begin
      same_d    = CNT_W'(1);
      mm_d      = '0;
      largest_d = '0;
    end else if (ctrl_i.vld) begin
      if (ctrl_i.dec_mode) begin
        if (eq) begin
          mm_d = mm_q + CNT_W'(1);
        end
        if (cur_cnt > largest_q) begin
          largest_d = cur_cnt;
        end
      end else if (eq) begin
        same_d = same_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      same_q    <= CNT_W'(1);
      mm_q      <= '0;
      largest_q <= '0;
    end else begin
      same_q    <= same_d;
      mm_q      <= mm_d;
      largest_q <= largest_d;
    end
  end

  // Bump the count of a stored entry that matches the new hash; store the
  // new entry's own count once its sweep is done.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      cnt_q[ctrl_i.wr_idx] <= same_q;
    end else if (ctrl_i.vld && !ctrl_i.dec_mode && !ctrl_i.clr && eq) begin
      cnt_q[ctrl_i.idx] <= cur_cnt + CNT_W'(1);
    end
  end

  assign stat_o.master_matches = mm_q;
  assign stat_o.largest        = largest_q;

endmodule

`default_nettype wire

FILE: hdl/rhv_ctrl.sv
// Sequencer: request capture, group state, compare/decide sweeps over the
// hash store, decision logic and the result register.
// Depends on rhv_pkg.
`default_nettype none

module rhv_ctrl
  import rhv_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [HASH_W-1:0] peer_hash_i,
  input  wire logic [ID_W-1:0]   claimed_leader_i,
  input  wire logic [ID_W-1:0]   node_id_i,
  input  wire logic              last_peer_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [DEC_W-1:0]  decision_o,
  output logic                   mem_wr_en_o,
  output logic      [IDX_W-1:0]  mem_wr_addr_o,
  output logic                   mem_rd_en_o,
  output logic      [IDX_W-1:0]  mem_rd_addr_o,
  output logic      [HASH_W-1:0] item_hash_o,
  output logic      [HASH_W-1:0] master_o,
  output tally_ctrl_t            tally_ctrl_o,
  input  wire tally_stat_t       tally_stat_i
);

  state_e            state_q, state_d;
  logic [HASH_W-1:0] hash_q;
  logic              lead_eq_q;
  logic              last_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [HASH_W-1:0] master_q, master_d;
  logic              found_q, found_d;
  logic              zero_q, zero_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              p_vld_q;
  logic [IDX_W-1:0]  p_idx_q;
  logic              out_valid_q, out_valid_d;
  decision_e         decision_q, decision_d;
  logic              accept;
  logic              issue;
  logic              sweep;
  logic              load;
  logic [CNT_W-1:0]  thr;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign sweep  = (state_q == ST_CMP) || (state_q == ST_DEC);
  assign issue  = sweep && (rd_idx_q < count_q);
  assign load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (count_q == MAX_CNT) begin
            state_d = last_peer_i ? ST_DEC : ST_IDLE;
          end else begin
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (!issue && !p_vld_q) begin
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        state_d = last_q ? ST_DEC : ST_IDLE;
      end
      ST_DEC: begin
        if (!issue && !p_vld_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Decision from the finished decide sweep.
  always_comb begin
    thr = {1'b0, count_q[CNT_W-1:1]} + CNT_W'(1);
    if (zero_q) begin
      decision_d = DEC_NONE;
    end else if (tally_stat_i.master_matches == count_q) begin
      decision_d = DEC_NONE;
    end else if (tally_stat_i.master_matches >= thr) begin
      decision_d = DEC_MINORITY;
    end else if (tally_stat_i.largest >= thr) begin
      decision_d = DEC_MASTER_MINORITY;
    end else begin
      decision_d = DEC_ALL;
    end
  end

  // Group state, read index and result register updates.
  always_comb begin
    count_d     = count_q;
    master_d    = master_q;
    found_d     = found_q;
    zero_d      = zero_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (issue) begin
      rd_idx_d = rd_idx_q + CNT_W'(1);
    end
    if (state_d != state_q && (state_d == ST_CMP || state_d == ST_DEC)) begin
      rd_idx_d = '0;
    end
    if (state_q == ST_WR) begin
      count_d = count_q + CNT_W'(1);
      if (!found_q && lead_eq_q) begin
        found_d  = 1'b1;
        master_d = hash_q;
      end
      if (hash_q == '0) begin
        zero_d = 1'b1;
      end
    end
    if (load) begin
      out_valid_d = 1'b1;
      count_d     = '0;
      master_d    = '0;
      found_d     = 1'b0;
      zero_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      master_q    <= '0;
      found_q     <= 1'b0;
      zero_q      <= 1'b0;
      rd_idx_q    <= '0;
      p_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      master_q    <= master_d;
      found_q     <= found_d;
      zero_q      <= zero_d;
      rd_idx_q    <= rd_idx_d;
      p_vld_q     <= issue;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hash_q    <= peer_hash_i;
      lead_eq_q <= (claimed_leader_i == node_id_i);
      last_q    <= last_peer_i;
    end
    if (issue) begin
      p_idx_q <= rd_idx_q[IDX_W-1:0];
    end
    if (load) begin
      decision_q <= decision_d;
    end
  end

  // Outputs toward memory, tally and ports.
  always_comb begin
    in_stall_o            = (state_q != ST_IDLE);
    out_valid_o           = out_valid_q;
    decision_o            = decision_q;
    mem_rd_en_o           = issue;
    mem_rd_addr_o         = rd_idx_q[IDX_W-1:0];
    mem_wr_en_o           = (state_q == ST_WR);
    mem_wr_addr_o         = count_q[IDX_W-1:0];
    item_hash_o           = hash_q;
    master_o              = master_q;
    tally_ctrl_o.clr      = (state_d != state_q) && (state_d == ST_CMP || state_d == ST_DEC);
    tally_ctrl_o.dec_mode = (state_q == ST_DEC);
    tally_ctrl_o.vld      = p_vld_q;
    tally_ctrl_o.idx      = p_idx_q;
    tally_ctrl_o.wr_en    = (state_q == ST_WR);
    tally_ctrl_o.wr_idx   = count_q[IDX_W-1:0];
  end

endmodule

`default_nettype wire

FILE: tb/rhv_vote_checker.sv
// Checker for the replica hash vote block: watches both channels, predicts the
// decision of every peer group and compares it with the decisions that leave.
// Depends on rhv_pkg.
`timescale 1ns / 1ps

module rhv_vote_checker
  import rhv_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire logic [HASH_W-1:0] peer_hash_i,
  input  wire logic [ID_W-1:0]   claimed_leader_i,
  input  wire logic [ID_W-1:0]   node_id_i,
  input  wire logic              last_peer_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire logic [DEC_W-1:0]  decision_i,
  output int                     fail_cnt_o,
  output int                     pending_o,
  output int                     decisions_o
);

  logic [HASH_W-1:0] seen_hash [MAX_PEERS];
  logic [CNT_W-1:0]  same_cnt  [MAX_PEERS];
  logic [CNT_W-1:0]  grp_n;
  logic [HASH_W-1:0] master_val;
  logic              has_master;
  logic              has_zero;
  decision_e         want_q[$];

  task automatic clear_group();
    grp_n      = '0;
    master_val = '0;
    has_master = 1'b0;
    has_zero   = 1'b0;
  endtask

  task automatic absorb_peer(logic [HASH_W-1:0] h, logic [ID_W-1:0] lead,
                             logic [ID_W-1:0] self);
    logic [CNT_W-1:0] same;
    same = CNT_W'(1);
    // drop peers past the group capacity
    if (grp_n >= MAX_CNT) return;
    for (int k = 0; k < int'(grp_n); k++) begin
      if (seen_hash[IDX_W'(k)] == h) begin
        same_cnt[IDX_W'(k)] = same_cnt[IDX_W'(k)] + 1'b1;
        same                = same + 1'b1;
      end
    end
    seen_hash[grp_n[IDX_W-1:0]] = h;
    same_cnt[grp_n[IDX_W-1:0]]  = same;
    if (!has_master && lead == self) begin
      has_master = 1'b1;
      master_val = h;
    end
    if (h == '0) has_zero = 1'b1;
    grp_n = grp_n + 1'b1;
  endtask

  function automatic decision_e judge_group();
    logic [CNT_W-1:0] quorum;
    logic [CNT_W-1:0] master_hits;
    logic [CNT_W-1:0] biggest;
    quorum      = (grp_n >> 1) + 1'b1;
    master_hits = '0;
    biggest     = '0;
    if (has_zero) return DEC_NONE;
    for (int k = 0; k < int'(grp_n); k++) begin
      if (seen_hash[IDX_W'(k)] == master_val) master_hits = master_hits + 1'b1;
      if (same_cnt[IDX_W'(k)] > biggest) biggest = same_cnt[IDX_W'(k)];
    end
    if (master_hits == grp_n) return DEC_NONE;
    if (master_hits >= quorum) return DEC_MINORITY;
    if (biggest >= quorum) return DEC_MASTER_MINORITY;
    return DEC_ALL;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decision_e want;
    if (!rst_ni) begin
      clear_group();
      want_q.delete();
      fail_cnt_o  = 0;
      pending_o   = 0;
      decisions_o = 0;
    end else begin
      // check the leaving decision first: it can never stem from a request
      // accepted at this same edge
      if (out_valid_i && !out_stall_i) begin
        decisions_o++;
        if (want_q.size() == 0) begin
          $error("decision: expected none, actual %0d", decision_i);
          fail_cnt_o++;
        end else begin
          want = want_q.pop_front();
          pending_o--;
          if (decision_i !== want) begin
            $error("decision: expected %0d, actual %0d", want, decision_i);
            fail_cnt_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_peer(peer_hash_i, claimed_leader_i, node_id_i);
        if (last_peer_i) begin
          want_q.push_back(judge_group());
          pending_o++;
          clear_group();
        end
      end
    end
  end

endmodule

FILE: tb/tb_replica_hash_vote_decision.sv
// Testbench top for replica_hash_vote_decision: drives peer groups with random
// gaps and result stalls, and reports the verdict from rhv_vote_checker.
// Depends on rhv_pkg, replica_hash_vote_decision and rhv_vote_checker.
`timescale 1ns / 1ps

module tb_replica_hash_vote_decision;
  import rhv_pkg::*;

  localparam int GRP_MAX    = 24;         // longest group driven, overflow included
  localparam int RAND_ITEMS = 650;        // random requests after the directed part
  localparam int DRAIN_CYC  = 64;         // covers the longest decide sweep
  localparam int TIMEOUT_NS = 2_000_000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [HASH_W-1:0] peer_hash;
  logic [ID_W-1:0]   claimed_leader;
  logic [ID_W-1:0]   node_id;
  logic              last_peer;
  logic              out_valid;
  logic              out_stall;
  logic [DEC_W-1:0]  decision;

  int fail_cnt;
  int pending;
  int decisions;

  // one group of peers, filled before it is sent
  logic [HASH_W-1:0] grp_hash [GRP_MAX];
  logic [ID_W-1:0]   grp_lead [GRP_MAX];
  logic [ID_W-1:0]   grp_node [GRP_MAX];

  int requests_sent;
  int groups_sent;
  int overflow_groups;
  bit send_quiet;
  bit recv_quiet;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  replica_hash_vote_decision dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .peer_hash_i      (peer_hash),
    .claimed_leader_i (claimed_leader),
    .node_id_i        (node_id),
    .last_peer_i      (last_peer),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .decision_o       (decision)
  );

  rhv_vote_checker u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .peer_hash_i      (peer_hash),
    .claimed_leader_i (claimed_leader),
    .node_id_i        (node_id),
    .last_peer_i      (last_peer),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .decision_i       (decision),
    .fail_cnt_o       (fail_cnt),
    .pending_o        (pending),
    .decisions_o      (decisions)
  );

  // Wait drawn per request or per decision; a quiet stretch forces zero so
  // that back-to-back traffic is exercised as well.
  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [HASH_W-1:0] rand_hash();
    return {$urandom, $urandom};
  endfunction

  // Offer one request and hold it until accepted. Valid is either kept high
  // or lowered for the gap, never both at one edge.
  task automatic send_peer(logic [HASH_W-1:0] h, logic [ID_W-1:0] lead,
                           logic [ID_W-1:0] self, logic last);
    int gap;
    gap = draw_wait(send_quiet);
    if ($urandom_range(0, 31) == 0) send_quiet = !send_quiet;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    peer_hash      <= h;
    claimed_leader <= lead;
    node_id        <= self;
    last_peer      <= last;
    // values read right after the edge are those the block sampled
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic send_group(int n);
    for (int i = 0; i < n; i++) begin
      send_peer(grp_hash[i], grp_lead[i], grp_node[i], i == n - 1);
    end
    groups_sent++;
    if (n > MAX_PEERS) overflow_groups++;
  endtask

  task automatic set_peer(int i, logic [HASH_W-1:0] h, logic [ID_W-1:0] lead,
                          logic [ID_W-1:0] self);
    grp_hash[i] = h;
    grp_lead[i] = lead;
    grp_node[i] = self;
  endtask

  // Well-formed group with random content: a small pool of hashes with a
  // favored one, a common leader id, and usually one peer that is the leader.
  // Some groups run past capacity, carry a zero hash, a second self-leader,
  // or peers that name a stray leader.
  task automatic random_group();
    int                n;
    int                r;
    int                pool_n;
    int                favor;
    int                pos;
    logic [HASH_W-1:0] pool [4];
    logic [ID_W-1:0]   lead;
    r = $urandom_range(0, 99);
    if (r < 60)      n = $urandom_range(1, 6);
    else if (r < 90) n = $urandom_range(7, MAX_PEERS);
    else             n = $urandom_range(MAX_PEERS + 1, GRP_MAX);
    pool_n = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) pool[i] = rand_hash();
    favor = $urandom_range(30, 100);
    lead  = ID_W'($urandom);
    for (int i = 0; i < n; i++) begin
      grp_hash[i] = ($urandom_range(1, 100) <= favor) ?
                    pool[0] : pool[$urandom_range(0, pool_n - 1)];
      grp_node[i] = lead ^ ID_W'($urandom_range(1, 255));
      grp_lead[i] = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : lead;
    end
    // place the leader, or leave the group without one
    if ($urandom_range(0, 5) != 0) begin
      pos = $urandom_range(0, n - 1);
      grp_lead[pos] = lead;
      grp_node[pos] = lead;
    end
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, n - 1);
      grp_node[pos] = grp_lead[pos];
    end
    if ($urandom_range(0, 7) == 0) grp_hash[$urandom_range(0, n - 1)] = '0;
    send_group(n);
  endtask

  // Result side: stall for a drawn number of cycles, then take one decision.
  initial begin
    int hold;
    out_stall = 1'b0;
    recv_quiet = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = draw_wait(recv_quiet);
      if ($urandom_range(0, 15) == 0) recv_quiet = !recv_quiet;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int rand_start;
    in_valid       = 1'b0;
    peer_hash      = '0;
    claimed_leader = '0;
    node_id        = '0;
    last_peer      = 1'b0;
    rst_n          = 1'b0;
    requests_sent   = 0;
    groups_sent     = 0;
    overflow_groups = 0;
    send_quiet      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single peer that is its own leader, all-ones hash: unanimous
    set_peer(0, '1, '1, '1);
    send_group(1);
    // single peer with no leader: master stays zero, its own hash wins
    set_peer(0, 64'h1, 8'h00, 8'hFF);
    send_group(1);
    // zero hash from the leader: no action
    set_peer(0, '0, 8'h07, 8'h07);
    send_group(1);
    // master holds a majority against one dissenter
    set_peer(0, 64'h8000_0000_0000_0000, 8'h10, 8'h10);
    set_peer(1, 64'h8000_0000_0000_0000, 8'h10, 8'h21);
    set_peer(2, 64'h7FFF_FFFF_FFFF_FFFF, 8'h10, 8'h32);
    send_group(3);
    // three different hashes: no majority anywhere
    set_peer(0, 64'h8000_0000_0000_0000, 8'hA5, 8'h5A);
    set_peer(1, 64'h7FFF_FFFF_FFFF_FFFF, 8'h5A, 8'h5A);
    set_peer(2, 64'h5555_AAAA_5555_AAAA, 8'h5A, 8'hC3);
    send_group(3);
    // full group, then a marked leader past capacity that must be dropped
    set_peer(0, 64'hFEDC_BA98_7654_3210, 8'h00, 8'h00);
    for (int i = 1; i < MAX_PEERS; i++) begin
      set_peer(i, 64'hFEDC_BA98_7654_3210, 8'h00, ID_W'(i));
    end
    set_peer(MAX_PEERS, 64'h0123_4567_89AB_CDEF, 8'hFF, 8'hFF);
    send_group(MAX_PEERS + 1);

    rand_start = requests_sent;
    while (requests_sent - rand_start < RAND_ITEMS) random_group();
    in_valid <= 1'b0;

    // let the checker register the last request, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d requests in %0d groups, %0d past capacity; %0d decisions checked.",
             requests_sent, groups_sent, overflow_groups, decisions);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d decisions outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
